FILE: rtl/gamepad_frame_receiver_macros.svh
// Assertion macros shared by the gamepad frame receiver RTL.
`ifndef GAMEPAD_FRAME_RECEIVER_MACROS_SVH
`define GAMEPAD_FRAME_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF
`define GFR_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("gfr assertion failed");
`define GFR_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("gfr forbidden condition seen");
`else
`define GFR_ASSERT(name, clk, rst_n, prop)
`define GFR_NEVER(name, clk, rst_n, cond)
`endif

`endif

FILE: rtl/gfr_pkg.sv
// Types and constants of the gamepad frame receiver.
package gfr_pkg;

	localparam logic [7:0] HEADER_RST  = 8'hEB;
	localparam logic [7:0] TRAILER_RST = 8'hAF;
	localparam logic [7:0] LIMIT_RST   = 8'd17;
	localparam int unsigned NUM_PAYLOAD = 6;

	typedef enum logic [1:0] {
		CFG_HEADER  = 2'd0,
		CFG_TRAILER = 2'd1,
		CFG_LIMIT   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_GOOD   = 2'd0,
		ST_NO_HDR = 2'd1,
		ST_BAD    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'd0,
		PH_LX      = 4'd1,
		PH_LY      = 4'd2,
		PH_RX      = 4'd3,
		PH_RY      = 4'd4,
		PH_BL      = 4'd5,
		PH_BH      = 4'd6,
		PH_SUM     = 4'd7,
		PH_TRAILER = 4'd8
	} phase_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] trailer_byte;
		logic [7:0] hunt_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  left_x;
		logic [7:0]  left_y;
		logic [7:0]  right_x;
		logic [7:0]  right_y;
		logic [15:0] buttons;
		status_t     status;
	} res_t;

endpackage

FILE: rtl/gfr_cfg_regs.sv
// Configuration register file: header, trailer and hunt limit.
module gfr_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [7:0]    wr_data,
	output gfr_pkg::cfg_t cfg
);
	import gfr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte  <= HEADER_RST;
			cfg_q.trailer_byte <= TRAILER_RST;
			cfg_q.hunt_limit   <= LIMIT_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_HEADER:  cfg_q.header_byte  <= wr_data;
				CFG_TRAILER: cfg_q.trailer_byte <= wr_data;
				CFG_LIMIT:   cfg_q.hunt_limit   <= wr_data;
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/gfr_parser.sv
// Frame parser: phase machine, miss counter, running sum and payload capture.
`include "gamepad_frame_receiver_macros.svh"

module gfr_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    byte_in,
	input  gfr_pkg::cfg_t cfg,
	output logic          emit,
	output gfr_pkg::res_t res
);
	import gfr_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] miss_q, miss_d;
	logic [7:0] sum_q, sum_d;
	logic       match_q, match_d;
	logic [7:0] payload_q [NUM_PAYLOAD];
	logic       wr_en;
	logic [2:0] wr_idx;
	logic       with_data;
	status_t    status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			miss_q  <= '0;
			sum_q   <= '0;
			match_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			miss_q  <= miss_d;
			sum_q   <= sum_d;
			match_q <= match_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && wr_en)
			payload_q[wr_idx] <= byte_in;
	end

	always_comb begin
		phase_d   = phase_q;
		miss_d    = miss_q;
		sum_d     = sum_q;
		match_d   = match_q;
		wr_en     = 1'b0;
		wr_idx    = '0;
		emit      = 1'b0;
		with_data = 1'b0;
		status    = ST_GOOD;
		unique case (phase_q)
			PH_LX, PH_LY, PH_RX, PH_RY, PH_BL, PH_BH: begin
				wr_en   = 1'b1;
				wr_idx  = 3'(4'(phase_q) - 4'd1);
				sum_d   = 8'(sum_q + byte_in);
				phase_d = phase_t'(4'(phase_q) + 4'd1);
			end
			PH_SUM: begin
				match_d = (byte_in == sum_q);
				phase_d = PH_TRAILER;
			end
			PH_TRAILER: begin
				emit      = 1'b1;
				with_data = 1'b1;
				status    = (match_q && byte_in == cfg.trailer_byte) ? ST_GOOD : ST_BAD;
				phase_d   = PH_HUNT;
				miss_d    = '0;
			end
			default: begin
				// hunting; unused codes behave the same
				phase_d = PH_HUNT;
				if (byte_in == cfg.header_byte) begin
					miss_d  = '0;
					sum_d   = '0;
					match_d = 1'b0;
					phase_d = PH_LX;
				end else if (miss_q >= cfg.hunt_limit) begin
					miss_d = '0;
					emit   = 1'b1;
					status = ST_NO_HDR;
				end else begin
					miss_d = 8'(miss_q + 8'd1);
				end
			end
		endcase
	end

	always_comb begin
		res.left_x  = with_data ? payload_q[0] : '0;
		res.left_y  = with_data ? payload_q[1] : '0;
		res.right_x = with_data ? payload_q[2] : '0;
		res.right_y = with_data ? payload_q[3] : '0;
		res.buttons = with_data ? {payload_q[5], payload_q[4]} : '0;
		res.status  = status;
	end

	`GFR_ASSERT(a_hdr_starts_frame, clk, arst_n,
		fire && phase_q == PH_HUNT && byte_in == cfg.header_byte |=> phase_q == PH_LX)
	`GFR_ASSERT(a_hdr_clears_state, clk, arst_n,
		fire && phase_q == PH_HUNT && byte_in == cfg.header_byte |=>
		miss_q == 8'd0 && sum_q == 8'd0 && !match_q)
	`GFR_ASSERT(a_sum_compare, clk, arst_n,
		fire && phase_q == PH_SUM |=> match_q == ($past(byte_in) == $past(sum_q)))

endmodule

FILE: rtl/gamepad_frame_receiver.sv
// Gamepad frame receiver: one byte per beat in, one frame or error result out.
// Last byte is held in the input register, then its result in the output register.
// Throughput: one byte per cycle; the input register stalls only when a result
// is due while the output register still holds one that is not taken.
// Reset: async active low; parser back to hunting, counters cleared, registers
// back to header 0xEB, trailer 0xAF, hunt limit 17. No clearing pass.
`include "gamepad_frame_receiver_macros.svh"

module gamepad_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  left_x,
	output logic [7:0]  left_y,
	output logic [7:0]  right_x,
	output logic [7:0]  right_y,
	output logic [15:0] buttons,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import gfr_pkg::*;

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       advance;
	logic       emit;
	res_t       res;
	logic       out_valid_q;
	res_t       res_q;
	logic       load;

	assign cfg_ready = 1'b1;

	gfr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	gfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.byte_in (rx_byte_s1),
		.cfg     (cfg),
		.emit    (emit),
		.res     (res)
	);

	// a byte with no result never waits on the output side
	assign advance  = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign load     = advance && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			rx_byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign left_x    = res_q.left_x;
	assign left_y    = res_q.left_y;
	assign right_x   = res_q.right_x;
	assign right_y   = res_q.right_y;
	assign buttons   = res_q.buttons;
	assign status    = res_q.status;

	`GFR_NEVER(a_no_overwrite, clk, arst_n, out_valid_q && !out_ready && load)
	`GFR_ASSERT(a_status_legal, clk, arst_n,
		out_valid_q |-> res_q.status == ST_GOOD || res_q.status == ST_NO_HDR ||
		res_q.status == ST_BAD)
	`GFR_ASSERT(a_no_hdr_zero, clk, arst_n,
		out_valid_q && res_q.status == ST_NO_HDR |->
		res_q.left_x == 8'd0 && res_q.left_y == 8'd0 && res_q.right_x == 8'd0 &&
		res_q.right_y == 8'd0 && res_q.buttons == 16'd0)

endmodule

FILE: dv/gamepad_frame_receiver_tb.sv
// Self-checking testbench for the gamepad frame receiver: directed table, then random traffic.
module gamepad_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gfr_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;   // no register behind this index
	localparam int SETTLE_CYCLES = 4;
	localparam int ITEMS_TARGET  = 1250;
	localparam int HOLD_CYCLES   = 150;
	localparam int NUM_ROWS      = 24;

	typedef struct {
		bit         is_cfg;
		logic [1:0] idx;
		logic [7:0] val;
		bit         typed;
		res_t       want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  left_x;
	logic [7:0]  left_y;
	logic [7:0]  right_x;
	logic [7:0]  right_y;
	logic [15:0] buttons;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	// sideband that travels with each input beat
	bit   tag_typed;
	res_t tag_want;

	// frame parser model
	cfg_t       regs = '{HEADER_RST, TRAILER_RST, LIMIT_RST};
	phase_t     ph = PH_HUNT;
	logic [7:0] misses = '0;
	logic [7:0] pay [NUM_PAYLOAD];
	logic [7:0] acc_sum = '0;
	bit         sum_ok = 1'b0;

	res_t frames_due [$];
	int   mismatches = 0;
	int   items_sent = 0;
	int   burst_left = 1;
	int   gap_max = 0;
	logic hold_tgl = 1'b0;
	row_t dir_tab [NUM_ROWS];

	// receiver stall state, owned by the receiver process
	logic       hold_seen = 1'b0;
	int         hold_left = 0;
	int         rmode = 0;
	int         rmode_left = 0;
	logic [7:0] pat_cnt = '0;

	gamepad_frame_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_x    (left_x),
		.left_y    (left_y),
		.right_x   (right_x),
		.right_y   (right_y),
		.buttons   (buttons),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void parse_byte(input logic [7:0] b, output bit got, output res_t r);
		got = 1'b0;
		r = '0;
		if (ph >= PH_LX && ph <= PH_BH) begin
			pay[int'(ph) - 1] = b;
			acc_sum = acc_sum + b;
			ph = phase_t'(ph + 4'd1);
		end else if (ph == PH_SUM) begin
			sum_ok = (b == acc_sum);
			ph = PH_TRAILER;
		end else if (ph == PH_TRAILER) begin
			r.left_x  = pay[0];
			r.left_y  = pay[1];
			r.right_x = pay[2];
			r.right_y = pay[3];
			r.buttons = {pay[5], pay[4]};
			r.status  = (sum_ok && b == regs.trailer_byte) ? ST_GOOD : ST_BAD;
			got = 1'b1;
			ph = PH_HUNT;
			misses = '0;
		end else begin
			ph = PH_HUNT;
			if (b == regs.header_byte) begin
				misses = '0;
				acc_sum = '0;
				sum_ok = 1'b0;
				ph = PH_LX;
			end else if (misses >= regs.hunt_limit) begin
				misses = '0;
				r.status = ST_NO_HDR;
				got = 1'b1;
			end else begin
				misses = misses + 8'd1;
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (mismatches < 50)
			$display("mismatch %s: want %h got %h at %0t", what, want, got, $time);
		mismatches++;
	endtask

	// input beats feed the model
	always @(posedge clk) begin : mon_in
		bit   got;
		res_t r;
		if (arst_n && in_valid && in_ready) begin
			parse_byte(rx_byte, got, r);
			if (tag_typed)
				frames_due.push_back(tag_want);
			else if (got)
				frames_due.push_back(r);
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEADER:  regs.header_byte  = cfg_data;
				CFG_TRAILER: regs.trailer_byte = cfg_data;
				CFG_LIMIT:   regs.hunt_limit   = cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin : mon_out
		res_t w;
		if (arst_n && out_valid && out_ready) begin
			if (frames_due.size() == 0) begin
				report_mismatch("result with none expected", 16'h0, {14'h0, status});
			end else begin
				w = frames_due.pop_front();
				if (left_x !== w.left_x)
					report_mismatch("left_x", 16'(w.left_x), 16'(left_x));
				if (left_y !== w.left_y)
					report_mismatch("left_y", 16'(w.left_y), 16'(left_y));
				if (right_x !== w.right_x)
					report_mismatch("right_x", 16'(w.right_x), 16'(right_x));
				if (right_y !== w.right_y)
					report_mismatch("right_y", 16'(w.right_y), 16'(right_y));
				if (buttons !== w.buttons) report_mismatch("buttons", w.buttons, buttons);
				if (status !== w.status)
					report_mismatch("status", 16'(w.status), 16'(status));
			end
		end
	end

	// receiver: mode segments plus a long hold on request
	always @(posedge clk) begin
		pat_cnt = pat_cnt + 8'd1;
		if (hold_tgl != hold_seen) begin
			hold_seen = hold_tgl;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (rmode_left == 0) begin
				rmode = $urandom_range(0, 3);
				rmode_left = $urandom_range(40, 300);
			end else begin
				rmode_left--;
			end
			case (rmode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= pat_cnt[1] ^ pat_cnt[3];
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic row_t byte_row(input logic [7:0] b);
		byte_row = '{1'b0, CFG_HEADER, b, 1'b0, res_t'('0)};
	endfunction

	function automatic row_t end_row(input logic [7:0] b, input res_t w);
		end_row = '{1'b0, CFG_HEADER, b, 1'b1, w};
	endfunction

	function automatic row_t cfg_row(input logic [1:0] idx, input logic [7:0] v);
		cfg_row = '{1'b1, idx, v, 1'b0, res_t'('0)};
	endfunction

	function automatic logic [7:0] data_byte();
		case ($urandom_range(0, 9))
			0: data_byte = 8'h00;
			1: data_byte = 8'hFF;
			default: data_byte = 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_byte(input logic [7:0] dflt);
		case ($urandom_range(0, 3))
			0: pick_byte = 8'h00;
			1: pick_byte = 8'hFF;
			2: pick_byte = dflt;
			default: pick_byte = 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic offer_byte(input logic [7:0] b, input bit typed, input res_t w);
		int gap;
		in_valid <= 1'b1;
		rx_byte <= b;
		tag_typed <= typed;
		tag_want <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send(input logic [7:0] b);
		offer_byte(b, 1'b0, res_t'('0));
	endtask

	// drop valid, wait for every frame due, then let the pipeline empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(input bit sum_good, input bit trl_good);
		logic [7:0] p;
		logic [7:0] s;
		s = '0;
		send(regs.header_byte);
		repeat (NUM_PAYLOAD) begin
			p = data_byte();
			s = s + p;
			send(p);
		end
		send(sum_good ? s : s ^ 8'($urandom_range(1, 255)));
		send(trl_good ? regs.trailer_byte : regs.trailer_byte ^ 8'($urandom_range(1, 255)));
	endtask

	// non-header bytes only, so misses pile up
	task automatic send_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = data_byte();
			if (b == regs.header_byte)
				b = ~b;
			send(b);
		end
	endtask

	initial begin
		int phase_no;
		int phase_end;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HEADER;
		cfg_data = '0;
		tag_typed = 1'b0;
		tag_want = '0;
		foreach (pay[i]) pay[i] = '0;
		dir_tab = '{
			byte_row(8'hEB), byte_row(8'h00), byte_row(8'hFF), byte_row(8'h00),
			byte_row(8'hFF), byte_row(8'h00), byte_row(8'hFF), byte_row(8'hFD),
			end_row(8'hAF, '{8'h00, 8'hFF, 8'h00, 8'hFF, 16'hFF00, ST_GOOD}),
			cfg_row(CFG_LIMIT, 8'h00),
			// zero limit: every non-header byte is a no-header error
			end_row(8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, ST_NO_HDR}),
			end_row(8'hFF, '{8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, ST_NO_HDR}),
			cfg_row(CFG_HEADER, 8'h00),
			cfg_row(CFG_TRAILER, 8'hFF),
			// header value inside the payload is plain data; sum is off by one
			byte_row(8'h00), byte_row(8'h80), byte_row(8'h00), byte_row(8'h7F),
			byte_row(8'hFE), byte_row(8'h55), byte_row(8'hAA), byte_row(8'hFD),
			end_row(8'hFF, '{8'h80, 8'h00, 8'h7F, 8'hFE, 16'hAA55, ST_BAD}),
			cfg_row(CFG_SPARE, 8'h5A)
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				wait_idle();
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				offer_byte(dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		phase_no = 0;
		while (items_sent < ITEMS_TARGET) begin
			wait_idle();
			if (phase_no == 2) begin
				// fill the block while the receiver holds off
				write_reg(CFG_LIMIT, 8'h00);
				gap_max = 0;
				hold_tgl <= ~hold_tgl;
				send_noise(200);
			end else begin
				if ($urandom_range(0, 3) != 0)
					write_reg(CFG_HEADER, pick_byte(HEADER_RST));
				if ($urandom_range(0, 3) != 0)
					write_reg(CFG_TRAILER, pick_byte(TRAILER_RST));
				if ($urandom_range(0, 3) != 0) begin
					case ($urandom_range(0, 4))
						0: write_reg(CFG_LIMIT, 8'h00);
						1: write_reg(CFG_LIMIT, 8'hFF);
						2: write_reg(CFG_LIMIT, LIMIT_RST);
						3: write_reg(CFG_LIMIT, 8'($urandom_range(1, 8)));
						default: write_reg(CFG_LIMIT, 8'($urandom_range(0, 255)));
					endcase
				end
				case ($urandom_range(0, 2))
					0: gap_max = 0;
					1: gap_max = 3;
					default: gap_max = 10;
				endcase
				phase_end = items_sent + $urandom_range(80, 160);
				while (items_sent < phase_end && items_sent < ITEMS_TARGET) begin
					pick = $urandom_range(0, 99);
					if (pick < 70) begin
						send_frame($urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
					end else if (pick < 85) begin
						send_noise($urandom_range(1, 24));
					end else if (pick < 95) begin
						// truncated frame; following bytes land in the payload
						send(regs.header_byte);
						repeat ($urandom_range(0, 7)) send(data_byte());
					end else begin
						wait_idle();
					end
				end
			end
			phase_no++;
		end

		wait_idle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
